@@ design/cab_pkg.sv @@
// Package with shared constants and types for the clipped alpha blitter.
package cab_pkg;

  localparam int unsigned FrameWidth  = 1024;
  localparam int unsigned FrameHeight = 1024;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned CountW  = 12;
  localparam int unsigned SumW    = 18;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [7:0]       AlphaKeep = 8'hf0;
  localparam logic [SizeW-1:0] RectMax   = 13'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    RegSrcOriginX = 3'd0,
    RegSrcOriginY = 3'd1,
    RegDstOriginX = 3'd2,
    RegDstOriginY = 3'd3,
    RegRectWidth  = 3'd4,
    RegRectHeight = 3'd5,
    RegSheetWidth = 3'd6,
    RegSheetHeight = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

@@ design/cab_blend.sv @@
// Combinational alpha blend of one source pixel over one destination pixel.
module cab_blend (
  input  logic [31:0]   src_pixel_i,
  input  cab_pkg::rgb_t dst_pixel_i,
  output cab_pkg::rgb_t pixel_o
);
  import cab_pkg::*;

  logic [7:0] alpha;
  logic [7:0] inv_alpha;
  rgb_t       src_rgb;
  rgb_t       mixed;

  function automatic logic [7:0] mix_chan(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] a, input logic [7:0] ia);
    logic [15:0] acc;
    acc = 16'(s) * 16'(ia) + 16'(d) * 16'(a);
    return acc[15:8];
  endfunction

  assign alpha     = src_pixel_i[31:24];
  assign inv_alpha = 8'hff - alpha;
  assign src_rgb   = src_pixel_i[23:0];

  assign mixed.red   = mix_chan(src_rgb.red,   dst_pixel_i.red,   alpha, inv_alpha);
  assign mixed.green = mix_chan(src_rgb.green, dst_pixel_i.green, alpha, inv_alpha);
  assign mixed.blue  = mix_chan(src_rgb.blue,  dst_pixel_i.blue,  alpha, inv_alpha);

  always_comb begin
    priority if (alpha >= AlphaKeep) begin
      pixel_o = dst_pixel_i;
    end else if (alpha == 8'h00) begin
      pixel_o = src_rgb;
    end else begin
      pixel_o = mixed;
    end
  end

endmodule

@@ design/clipped_alpha_blit_top.sv @@
// Clipped alpha blitter: walks a rectangle, clips each position and blends the pixel.
// A request accepted on the slave side passes through the input register and then
// the result register before its result shows on the master side.
// Throughput: one request per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result side holds tready low.
// Reset: origins clear to 0, rectangle size to 1, sheet size to 0, the walk
// counters to the first position, and both pipeline stages empty.
module clipped_alpha_blit_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cab_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cab_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: src_pixel [31:0], dst_pixel [55:32]
  input  logic [55:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: out_x [15:0], out_y [31:16], out_pixel [55:32]
  output logic [55:0]                  m_axis_tdata,
  // tuser: write_enable [0]
  output logic                         m_axis_tuser,
  output logic                         m_axis_tlast
);
  import cab_pkg::*;

  localparam logic signed [SumW-1:0] FrameWidthS  = SumW'(FrameWidth);
  localparam logic signed [SumW-1:0] FrameHeightS = SumW'(FrameHeight);

  // Configuration registers.
  logic [CoordW-1:0] src_origin_x_q, src_origin_y_q, dst_origin_x_q, dst_origin_y_q;
  logic [SizeW-1:0]  rect_width_q, rect_height_q, sheet_width_q, sheet_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_origin_x_q <= '0;
      src_origin_y_q <= '0;
      dst_origin_x_q <= '0;
      dst_origin_y_q <= '0;
      rect_width_q   <= SizeW'(1);
      rect_height_q  <= SizeW'(1);
      sheet_width_q  <= '0;
      sheet_height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegSrcOriginX:  src_origin_x_q <= cfg_data_i;
        RegSrcOriginY:  src_origin_y_q <= cfg_data_i;
        RegDstOriginX:  dst_origin_x_q <= cfg_data_i;
        RegDstOriginY:  dst_origin_y_q <= cfg_data_i;
        RegRectWidth:   rect_width_q   <= cfg_data_i[SizeW-1:0];
        RegRectHeight:  rect_height_q  <= cfg_data_i[SizeW-1:0];
        RegSheetWidth:  sheet_width_q  <= cfg_data_i[SizeW-1:0];
        RegSheetHeight: sheet_height_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Index of the last column and row; a size of zero acts as one, above the
  // maximum it acts as the maximum.
  function automatic logic [CountW-1:0] last_index(input logic [SizeW-1:0] size);
    logic [SizeW-1:0] eff;
    eff = size;
    if (eff == '0) eff = SizeW'(1);
    if (eff > RectMax) eff = RectMax;
    return CountW'(eff - SizeW'(1));
  endfunction

  // Handshake and pipeline control.
  logic s1_valid_q, out_valid_q;
  logic out_adv, s1_adv, in_accept;

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s1_adv        = !s1_valid_q || out_adv;
  assign s_axis_tready = s1_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Walk counters, advanced on each accepted request.
  logic [CountW-1:0] col_count_q, row_count_q;
  logic              row_end, rect_end;

  assign row_end  = col_count_q >= last_index(rect_width_q);
  assign rect_end = row_count_q >= last_index(rect_height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (in_accept) begin
      if (row_end) begin
        col_count_q <= '0;
        row_count_q <= rect_end ? '0 : row_count_q + CountW'(1);
      end else begin
        col_count_q <= col_count_q + CountW'(1);
      end
    end
  end

  // Input register stage.
  logic [31:0]       s1_src_q;
  rgb_t              s1_dst_q;
  logic [CountW-1:0] s1_col_q, s1_row_q;
  logic              s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_src_q  <= s_axis_tdata[31:0];
      s1_dst_q  <= s_axis_tdata[55:32];
      s1_col_q  <= col_count_q;
      s1_row_q  <= row_count_q;
      s1_last_q <= row_end && rect_end;
    end
  end

  // Coordinates and clipping.
  function automatic logic signed [SumW-1:0] place(input logic [CoordW-1:0] origin,
                                                   input logic [CountW-1:0] offset);
    return $signed({{(SumW-CoordW){origin[CoordW-1]}}, origin}) +
           $signed({{(SumW-CountW){1'b0}}, offset});
  endfunction

  logic signed [SumW-1:0] sx, sy, dx, dy;
  logic                   in_bounds;
  rgb_t                   blended;

  assign sx = place(src_origin_x_q, s1_col_q);
  assign sy = place(src_origin_y_q, s1_row_q);
  assign dx = place(dst_origin_x_q, s1_col_q);
  assign dy = place(dst_origin_y_q, s1_row_q);

  assign in_bounds = (sx >= 0) && (sx < $signed({{(SumW-SizeW){1'b0}}, sheet_width_q})) &&
                     (sy >= 0) && (sy < $signed({{(SumW-SizeW){1'b0}}, sheet_height_q})) &&
                     (dx >= 0) && (dx < FrameWidthS) &&
                     (dy >= 0) && (dy < FrameHeightS);

  cab_blend u_blend (
    .src_pixel_i (s1_src_q),
    .dst_pixel_i (s1_dst_q),
    .pixel_o     (blended)
  );

  // Result register stage.
  logic [CoordW-1:0] out_x_q, out_y_q;
  rgb_t              out_pixel_q;
  logic              out_we_q, out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_x_q     <= dx[CoordW-1:0];
      out_y_q     <= dy[CoordW-1:0];
      out_pixel_q <= in_bounds ? blended : '0;
      out_we_q    <= in_bounds;
      out_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pixel_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_we_q;
  assign m_axis_tlast  = out_last_q;

endmodule
